>>> hw/rtl/feedforward_echo_comb_assert.svh
// Assertion macros for the feedforward echo comb.
// Included by the modules that carry concurrent checks; expands to nothing
// when SYNTHESIS is defined.
`ifndef FEEDFORWARD_ECHO_COMB_ASSERT_SVH
`define FEEDFORWARD_ECHO_COMB_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every clock edge outside of reset
`define FEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("feedforward_echo_comb: assertion failed");
// checked on every clock edge, reset included
`define FEC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("feedforward_echo_comb: assertion failed during reset");
`else
`define FEC_ASSERT(lbl, prop)
`define FEC_ASSERT_RST(lbl, prop)
`endif
`endif

>>> hw/rtl/fec_pkg.sv
// Shared constants for the feedforward echo comb: register map,
// register reset values and the fixed-point format of the gain.
// No dependencies.
package fec_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] DELAY_RESET = 16'd4800;
  localparam logic [CFG_DATA_W-1:0] GAIN_RESET  = 16'd32768;

  // gain is unsigned Q0.16
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned GAIN_FRAC = 16;

endpackage

>>> hw/rtl/feedforward_echo_comb.sv
// Feedforward echo comb: y = x + a * x[n-d], saturated, with a delay-line memory.
// Depends on fec_pkg and feedforward_echo_comb_assert.svh.
//
// An accepted input word passes stage A, stage B and the output register in turn.
// Throughput: one word per cycle while the output is not stalled; pipeline bubbles collapse under output stall.
// Rate is set by the delay memory: one write and one registered read per word.
// Reset clears the pipeline valids, write pointer and sound count and loads the
// register reset values; the delay memory is not cleared and needs no sweep.
module feedforward_echo_comb #(
  parameter int unsigned MAX_DELAY   = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in_i,
  input  logic                               last_in_sound_i,
  // output words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  output logic                               saturated_o,
  output logic                               last_out_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fec_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fec_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  `include "feedforward_echo_comb_assert.svh"

  localparam int unsigned AW = $clog2(MAX_DELAY);       // memory address
  localparam int unsigned DW = $clog2(MAX_DELAY + 1);   // holds MAX_DELAY itself
  localparam int unsigned LW = (DW > fec_pkg::CFG_DATA_W) ? DW : fec_pkg::CFG_DATA_W;
  localparam int unsigned PW = SAMPLE_BITS + fec_pkg::GAIN_W + 1;  // product
  localparam int unsigned TW = PW - fec_pkg::GAIN_FRAC;           // echo term
  localparam int unsigned SW = SAMPLE_BITS + 2;                    // sum

  localparam logic [DW-1:0] MAX_D      = DW'(MAX_DELAY);
  localparam logic [AW-1:0] WP_LAST    = AW'(MAX_DELAY - 1);
  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (fec_pkg::GAIN_FRAC - 1);
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [fec_pkg::CFG_DATA_W-1:0] delay_q, gain_q;
  logic                           cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= fec_pkg::DELAY_RESET;
      gain_q  <= fec_pkg::GAIN_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        fec_pkg::REG_DELAY: delay_q <= cfg_data_i;
        fec_pkg::REG_GAIN:  gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage enables: a stage loads when it is empty or its successor moves
  logic a_v_q, b_v_q, out_v_q;
  logic en_a, en_b, en_c, in_acc;

  assign en_c       = !out_v_q || !out_stall_i;
  assign en_b       = !b_v_q || en_c;
  assign en_a       = !a_v_q || en_b;
  assign in_stall_o = !en_a;
  assign in_acc     = in_valid_i && en_a;

  // ---------------------------------------------------------------------------
  // delay clipping, read address and echo gating at accept time
  logic [AW-1:0] wp_q, wp_d, rd_addr;
  logic [DW-1:0] seen_q, seen_d, d_eff, rd_w;
  logic          echo_en;

  always_comb begin
    // delay above the store depth acts as the full depth
    if (LW'(delay_q) > LW'(MAX_DELAY)) begin
      d_eff = MAX_D;
    end else begin
      d_eff = DW'(delay_q);
    end

    if (DW'(wp_q) >= d_eff) begin
      rd_w = DW'(wp_q) - d_eff;
    end else begin
      rd_w = DW'(wp_q) + (MAX_D - d_eff);
    end
    rd_addr = rd_w[AW-1:0];

    echo_en = (d_eff != '0) && (seen_q >= d_eff);

    // count of samples seen in this sound, held at the delay
    if (last_in_sound_i) begin
      seen_d = '0;
    end else if (seen_q >= d_eff) begin
      seen_d = d_eff;
    end else begin
      seen_d = seen_q + DW'(1);
    end

    wp_d = (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      seen_q <= '0;
    end else if (in_acc) begin
      wp_q   <= wp_d;
      seen_q <= seen_d;
    end
  end

  // ---------------------------------------------------------------------------
  // delay memory, read before write when both hit one entry
  logic [SAMPLE_BITS-1:0] hist_mem [MAX_DELAY];
  logic [SAMPLE_BITS-1:0] a_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hist_mem[wp_q] <= sample_in_i;
    end
    if (en_a) begin
      a_rd_q <= hist_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // stage A: input register
  logic signed [SAMPLE_BITS-1:0] a_x_q;
  logic                          a_last_q, a_echo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_a) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_x_q    <= sample_in_i;
      a_last_q <= last_in_sound_i;
      a_echo_q <= echo_en;
    end
  end

  // ---------------------------------------------------------------------------
  // stage B: scale the delayed sample by the gain
  logic signed [SAMPLE_BITS-1:0]        past_s;
  logic signed [fec_pkg::GAIN_W:0]      gain_s;
  logic signed [PW-1:0]                 prod_d, b_prod_q;
  logic signed [SAMPLE_BITS-1:0]        b_x_q;
  logic                                 b_last_q;

  assign past_s = a_echo_q ? $signed(a_rd_q) : '0;
  assign gain_s = $signed({1'b0, gain_q});
  assign prod_d = past_s * gain_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_b) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_prod_q <= prod_d;
      b_x_q    <= a_x_q;
      b_last_q <= a_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage C: round half up, add, saturate into the output register
  logic [PW-1:0]                 rnd;
  logic signed [TW-1:0]          term;
  logic signed [SW-1:0]          sum;
  logic                          ovf;
  logic [SAMPLE_BITS-1:0]        y_d;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic                          sat_q, last_q;

  always_comb begin
    rnd  = b_prod_q + ROUND_HALF;
    term = $signed(rnd[PW-1:fec_pkg::GAIN_FRAC]);
    sum  = SW'(b_x_q) + SW'(term);
    ovf  = (sum[SW-1:SAMPLE_BITS-1] != '0) && (sum[SW-1:SAMPLE_BITS-1] != '1);
    if (ovf) begin
      y_d = sum[SW-1] ? SMP_MIN : SMP_MAX;
    end else begin
      y_d = sum[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_c) begin
      out_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      y_q    <= $signed(y_d);
      sat_q  <= ovf;
      last_q <= b_last_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign sample_out_o = y_q;
  assign saturated_o  = sat_q;
  assign last_out_o   = last_q;

  // ---------------------------------------------------------------------------
  // checks
  `FEC_ASSERT(a_sound_restart, in_acc && last_in_sound_i |=> seen_q == '0)
  `FEC_ASSERT(a_wp_holds, !in_acc |=> $stable(wp_q))
  `FEC_ASSERT(a_wp_moves, in_acc |=> wp_q != $past(wp_q))
  `FEC_ASSERT(a_stage_a_fill, in_acc |=> a_v_q)
  `FEC_ASSERT(a_stage_b_fill, a_v_q && en_b |=> b_v_q)
  `FEC_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o && !a_v_q && !b_v_q)

endmodule

>>> tb/feedforward_echo_comb_checker.sv
`timescale 1ns / 100ps
// Passive checker for feedforward_echo_comb: watches the input, output and
// configuration channels, predicts each output word and compares it.
// Depends on fec_pkg only.
module feedforward_echo_comb_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [15:0]                    sample_in_i,
  input  logic                           last_in_sound_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [15:0]                    sample_out_i,
  input  logic                           saturated_i,
  input  logic                           last_out_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [fec_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fec_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  localparam longint SMP_MAX    = 32767;
  localparam longint SMP_MIN    = -32768;
  localparam int     REPORT_MAX = 10;

  typedef struct packed {
    logic [15:0] smp;
    logic        sat;
    logic        last;
  } echo_word_t;

  // shadow of the block: registers, delay line, pointer and sound count
  logic [15:0]        delay_q;
  logic [15:0]        gain_q;
  logic signed [15:0] echo_line [0:65535];
  logic [15:0]        wr_ptr;
  int unsigned        seen_cnt;

  echo_word_t         expected_q[$];
  echo_word_t         want;
  int                 fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // y = x + round(a * x[n-d]), saturated; echo only after d samples of the sound
  function automatic echo_word_t predict_echo(input logic signed [15:0] x,
                                              input logic last);
    echo_word_t  r;
    longint      y;
    longint      past;
    logic [15:0] rd_idx;
    if (seen_cnt > delay_q) seen_cnt = delay_q;
    y = x;
    if (delay_q != 0 && seen_cnt >= delay_q) begin
      rd_idx = wr_ptr - delay_q;
      past   = echo_line[rd_idx];
      // arithmetic shift gives floor, so this rounds half up
      y = y + ((past * longint'(gain_q) + 64'sd32768) >>> 16);
    end
    r.sat = 1'b0;
    if (y > SMP_MAX) begin
      y     = SMP_MAX;
      r.sat = 1'b1;
    end
    if (y < SMP_MIN) begin
      y     = SMP_MIN;
      r.sat = 1'b1;
    end
    r.smp  = y[15:0];
    r.last = last;
    echo_line[wr_ptr] = x;
    wr_ptr = wr_ptr + 16'd1;
    if (last) seen_cnt = 0;
    else if (seen_cnt < delay_q) seen_cnt++;
    return r;
  endfunction

  task automatic report_failure(input string what);
    fails++;
    if (fails <= REPORT_MAX) begin
      $display("%0t: %s: expected smp=%0d sat=%0b last=%0b, got smp=%0d sat=%0b last=%0b",
               $time, what, $signed(want.smp), want.sat, want.last,
               $signed(sample_out_i), saturated_i, last_out_i);
    end
  endtask

  // watch all channels; pop before push so a word never matches itself
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  = fec_pkg::DELAY_RESET;
      gain_q   = fec_pkg::GAIN_RESET;
      wr_ptr   = '0;
      seen_cnt = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fec_pkg::REG_DELAY: delay_q = cfg_data_i;
          fec_pkg::REG_GAIN:  gain_q  = cfg_data_i;
          default:   ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          want = '0;
          report_failure("output word with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (want.smp !== sample_out_i || want.sat !== saturated_i ||
              want.last !== last_out_i) begin
            report_failure("output word mismatch");
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_echo(sample_in_i, last_in_sound_i));
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> tb/tb_feedforward_echo_comb.sv
`timescale 1ns / 100ps
// Testbench top for feedforward_echo_comb: clock, reset, stimulus and verdict.
// Depends on fec_pkg, feedforward_echo_comb and feedforward_echo_comb_checker.
module tb_feedforward_echo_comb;

  localparam int unsigned DRAIN_CYCLES = 8;      // pipeline latency plus margin
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned LONG_DELAY   = 65535;
  localparam int unsigned LONG_EXTRA   = 24;
  localparam logic [fec_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [fec_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid      = 1'b0;
  logic                           in_stall;
  logic [15:0]                    sample_in     = '0;
  logic                           last_in_sound = 1'b0;
  logic                           out_valid;
  logic                           out_stall     = 1'b0;
  logic [15:0]                    sample_out;
  logic                           saturated;
  logic                           last_out;
  logic                           cfg_valid     = 1'b0;
  logic                           cfg_ready;
  logic [fec_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [fec_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  int fail_count;
  int pending;
  bit idle_en    = 1'b0;
  bit hold_req   = 1'b0;
  int stall_left = 0;

  feedforward_echo_comb dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_in_i     (sample_in),
    .last_in_sound_i (last_in_sound),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sample_out_o    (sample_out),
    .saturated_o     (saturated),
    .last_out_o      (last_out),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  feedforward_echo_comb_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .sample_in_i     (sample_in),
    .last_in_sound_i (last_in_sound),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .sample_out_i    (sample_out),
    .saturated_i     (saturated),
    .last_out_i      (last_out),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // output side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // mostly uniform, with the rails showing up often
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input word; valid stays high for a following word
  task automatic send_word(input logic [15:0] smp, input logic last);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    sample_in     <= smp;
    last_in_sound <= last;
    do @(posedge clk_i); while (in_stall);
  endtask

  // stop sending and wait until every expected word is out
  task automatic drain();
    int n;
    in_valid <= 1'b0;
    @(posedge clk_i);
    n = 0;
    while (pending != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // two register writes back to back, block idle
  task automatic write_regs(input logic [fec_pkg::CFG_IDX_W-1:0] idx_a,
                            input logic [fec_pkg::CFG_DATA_W-1:0] val_a,
                            input logic [fec_pkg::CFG_IDX_W-1:0] idx_b,
                            input logic [fec_pkg::CFG_DATA_W-1:0] val_b);
    cfg_valid <= 1'b1;
    cfg_index <= idx_a;
    cfg_data  <= val_a;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= idx_b;
    cfg_data  <= val_b;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // sounds of random length with random samples
  task automatic run_sounds(input int n_items, input int max_len);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      for (k = 0; k < len && sent < n_items; k++) begin
        send_word(rand_sample(), k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    int seg;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: long delay, so no echo yet
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b1);
    drain();
    write_regs(REG_SPARE_A, 16'hFFFF, REG_SPARE_B, 16'h0000);

    // delay of one, full gain: clipping at both rails, then a sound restart
    write_regs(fec_pkg::REG_DELAY, 16'd1, fec_pkg::REG_GAIN, 16'hFFFF);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0001, 1'b1);
    send_word(16'h0005, 1'b0);
    drain();

    // zero gain
    write_regs(fec_pkg::REG_DELAY, 16'd1, fec_pkg::REG_GAIN, 16'h0000);
    send_word(16'd100, 1'b0);
    send_word(16'hFFF9, 1'b1);
    drain();

    // zero delay
    write_regs(fec_pkg::REG_DELAY, 16'd0, fec_pkg::REG_GAIN, 16'hFFFF);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h7FFF, 1'b1);
    drain();

    // half gain rounding, then the delay shrinks in the middle of a sound
    write_regs(fec_pkg::REG_DELAY, 16'd6, fec_pkg::REG_GAIN, 16'h8000);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0003, 1'b0);
    send_word(16'hFFFD, 1'b0);
    drain();
    write_regs(fec_pkg::REG_DELAY, 16'd2, fec_pkg::REG_GAIN, 16'h8000);
    send_word(16'hFFFD, 1'b0);
    send_word(16'h0003, 1'b1);
    drain();

    // random sounds under several settings, with idling on both sides
    idle_en = 1'b1;
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          write_regs(fec_pkg::REG_DELAY, 16'($urandom_range(1, 8)),
                     fec_pkg::REG_GAIN, 16'($urandom));
          hold_req = 1'b1;
          run_sounds(200, 40);
        end
        1: begin
          write_regs(fec_pkg::REG_DELAY, 16'($urandom_range(1, 40)),
                     fec_pkg::REG_GAIN, 16'hFFFF);
          run_sounds(75, 120);
          drain();
          run_sounds(75, 120);
        end
        2: begin
          write_regs(fec_pkg::REG_DELAY, 16'($urandom_range(50, 300)),
                     fec_pkg::REG_GAIN, 16'($urandom_range(1, 65535)));
          run_sounds(250, 600);
        end
        default: begin
          write_regs(fec_pkg::REG_DELAY, 16'($urandom_range(1, 16)),
                     fec_pkg::REG_GAIN, 16'd1);
          run_sounds(100, 50);
          drain();
          write_regs(fec_pkg::REG_DELAY, 16'($urandom_range(1, 16)),
                     fec_pkg::REG_GAIN, 16'($urandom_range(1, 65535)));
          run_sounds(100, 50);
        end
      endcase
      drain();
    end

    // longest delay, no idling: a short sound that stays clear of the echo
    idle_en = 1'b0;
    send_word(rand_sample(), 1'b1);
    drain();
    write_regs(fec_pkg::REG_DELAY, 16'(LONG_DELAY),
               fec_pkg::REG_GAIN, 16'($urandom_range(1, 65535)));
    for (int i = 0; i < LONG_EXTRA; i++) begin
      send_word(rand_sample(), i == LONG_EXTRA - 1);
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
